// ===== design/delta_peak_valley_detector_unit_assert.svh =====
// Assertion macros shared by the detector modules.
// Both expect clk_i in the scope where they are used; DPVD_ASSERT also expects rst_ni.
`ifndef DELTA_PEAK_VALLEY_DETECTOR_UNIT_ASSERT_SVH
`define DELTA_PEAK_VALLEY_DETECTOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define DPVD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define DPVD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define DPVD_ASSERT(lbl, prop, msg)
`define DPVD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/dpvd_pkg.sv =====
package dpvd_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned DELTA_W    = 16;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned TOTAL_W    = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  // Wide enough for a sample plus or minus the full threshold.
  localparam int unsigned CMP_W      = SAMPLE_W + 2;

  typedef enum logic [1:0] {
    KIND_PEAK   = 2'd0,
    KIND_VALLEY = 2'd1,
    KIND_END    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_DONE        = 2'd0,
    STAT_PEAK_FULL   = 2'd1,
    STAT_VALLEY_FULL = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELTA      = 2'd0,
    CFG_SEEK_PEAK  = 2'd1,
    CFG_PEAK_CAP   = 2'd2,
    CFG_VALLEY_CAP = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PRIME,
    ST_START,
    ST_FETCH,
    ST_EVAL,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       last_sample;
  } dpvd_sample_t;

  typedef struct packed {
    logic [1:0]         record_kind;
    logic [POS_W-1:0]   position;
    logic [1:0]         scan_status;
    logic [TOTAL_W-1:0] peak_total;
    logic [TOTAL_W-1:0] valley_total;
    logic               last_record;
  } dpvd_record_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_wr;
    logic prime_rd;
    logic start_scan;
    logic fetch_rd;
    logic step;
    logic stop;
    logic emit_end;
  } dpvd_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic more;
    logic find;
    logic cap_full;
    logic slot_free;
  } dpvd_stat_t;

endpackage

// ===== design/dpvd_stream_if.sv =====
interface dpvd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/delta_peak_valley_detector_unit.sv =====
// Delta peak/valley detector. Samples of a frame are taken one per cycle into
// a single-port sample store until the item flagged last_sample; the block then
// stops taking items and scans the stored frame, alternately confirming a peak
// (a drop of more than delta_threshold below the running maximum) and a valley
// (a rise of more than delta_threshold above the running minimum). Each find is
// sent as a record, and the scan rewinds to the found position. A frame ends
// with one end record carrying the status and the peak and valley counts.
// Scan steps: a setup read of the first sample (ST_PRIME) and the tracker start
// (ST_START), then per visited sample one store read (ST_FETCH) and one compare
// step (ST_EVAL); samples between a find's position and the point that confirmed
// it are visited again. A last fetch sees that the frame is exhausted (not spent
// when a full peak or valley list stops the scan), then the end record is sent.
// A stalled record output holds the scan.
// Samples beyond MAX_SAMPLES are dropped. The store needs no clearing after
// reset; the scan reads only samples written in the current frame.
module delta_peak_valley_detector_unit #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dpvd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dpvd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  dpvd_stream_if.sink                     smp_i,
  dpvd_stream_if.source                   rec_o
);
  import dpvd_pkg::*;

  dpvd_cmd_t  cmd;
  dpvd_stat_t stat;

  dpvd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (smp_i.valid),
    .in_last_i  (smp_i.payload.last_sample),
    .in_ready_o (smp_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dpvd_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_value_i (smp_i.payload.sample_value),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .rec_valid_o    (rec_o.valid),
    .rec_ready_i    (rec_o.ready),
    .rec_o          (rec_o.payload)
  );

endmodule

// ===== design/dpvd_ctrl.sv =====
`include "delta_peak_valley_detector_unit_assert.svh"

module dpvd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  input  dpvd_pkg::dpvd_stat_t stat_i,
  output dpvd_pkg::dpvd_cmd_t  cmd_o
);
  import dpvd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i && in_last_i) state_d = ST_PRIME;
      end
      ST_PRIME: state_d = ST_START;
      ST_START: state_d = ST_FETCH;
      ST_FETCH: begin
        state_d = stat_i.more ? ST_EVAL : ST_FINISH;
      end
      ST_EVAL: begin
        if (stat_i.find && stat_i.cap_full) begin
          state_d = ST_FINISH;
        end else if (!stat_i.find || stat_i.slot_free) begin
          state_d = ST_FETCH;
        end
      end
      ST_FINISH: begin
        if (stat_i.slot_free) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o    = 1'b1;
        cmd_o.load_wr = in_valid_i;
      end
      ST_PRIME: cmd_o.prime_rd = 1'b1;
      ST_START: cmd_o.start_scan = 1'b1;
      ST_FETCH: cmd_o.fetch_rd = stat_i.more;
      ST_EVAL: begin
        // A find waits here until the record slot can take it.
        if (stat_i.find && stat_i.cap_full) begin
          cmd_o.stop = 1'b1;
        end else if (!stat_i.find || stat_i.slot_free) begin
          cmd_o.step = 1'b1;
        end
      end
      ST_FINISH: cmd_o.emit_end = stat_i.slot_free;
      default: ;
    endcase
  end

  `DPVD_ASSERT(a_find_into_free_slot, cmd_o.step && stat_i.find |-> stat_i.slot_free, "find record emitted into a busy slot")
  `DPVD_ASSERT(a_end_returns_to_load, cmd_o.emit_end |=> in_ready_o, "block did not return to loading after the end record")
  `DPVD_ASSERT(a_no_read_while_loading, cmd_o.load_wr |-> !(cmd_o.prime_rd || cmd_o.fetch_rd), "store read and write in the same cycle")

endmodule

// ===== design/dpvd_dp.sv =====
`include "delta_peak_valley_detector_unit_assert.svh"

module dpvd_dp #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [dpvd_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [dpvd_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic signed [dpvd_pkg::SAMPLE_W-1:0]   sample_value_i,
  input  dpvd_pkg::dpvd_cmd_t                    cmd_i,
  output dpvd_pkg::dpvd_stat_t                   stat_o,
  output logic                                   rec_valid_o,
  input  logic                                   rec_ready_i,
  output dpvd_pkg::dpvd_record_t                 rec_o
);
  import dpvd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned NW = $clog2(MAX_SAMPLES + 1);

  // Configuration registers.
  logic [DELTA_W-1:0] delta_q;
  logic               seek_q;
  logic [TOTAL_W-1:0] pcap_q, vcap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= '0;
      seek_q  <= 1'b1;
      pcap_q  <= '1;
      vcap_q  <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DELTA:      delta_q <= cfg_wdata_i[DELTA_W-1:0];
        CFG_SEEK_PEAK:  seek_q  <= cfg_wdata_i[0];
        CFG_PEAK_CAP:   pcap_q  <= cfg_wdata_i[TOTAL_W-1:0];
        CFG_VALLEY_CAP: vcap_q  <= cfg_wdata_i[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample store.
  logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
  logic [SAMPLE_W-1:0] rdata_q;
  logic [NW-1:0]       cnt_q, idx_q, idx_d;
  logic                wr_en, rd_en;
  logic [AW-1:0]       raddr;

  assign wr_en = cmd_i.load_wr && (cnt_q < NW'(MAX_SAMPLES));
  assign rd_en = cmd_i.prime_rd || cmd_i.fetch_rd;
  assign raddr = cmd_i.prime_rd ? '0 : idx_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[cnt_q[AW-1:0]] <= sample_value_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[raddr];
  end

  // Tracker state.
  logic signed [SAMPLE_W-1:0] run_max_q, run_min_q, max_n, min_n, v;
  logic [AW-1:0]              max_pos_q, min_pos_q, max_pos_n, min_pos_n;
  logic                       seeking_q;
  logic [TOTAL_W-1:0]         peaks_q, valleys_q;
  status_e                    status_q;
  logic                       find_peak, find_valley;
  logic signed [CMP_W-1:0]    v_w, max_w, min_w, dlt_w;

  assign v = $signed(rdata_q);

  always_comb begin
    max_n     = run_max_q;
    max_pos_n = max_pos_q;
    min_n     = run_min_q;
    min_pos_n = min_pos_q;
    if (v > run_max_q) begin
      max_n     = v;
      max_pos_n = idx_q[AW-1:0];
    end
    if (v < run_min_q) begin
      min_n     = v;
      min_pos_n = idx_q[AW-1:0];
    end
  end

  assign v_w   = CMP_W'(v);
  assign max_w = CMP_W'(max_n);
  assign min_w = CMP_W'(min_n);
  assign dlt_w = CMP_W'({1'b0, delta_q});

  assign find_peak   = seeking_q && (v_w < max_w - dlt_w);
  assign find_valley = !seeking_q && (v_w > min_w + dlt_w);

  always_comb begin
    idx_d = idx_q + NW'(1);
    if (find_peak) begin
      idx_d = NW'(max_pos_n);
    end else if (find_valley) begin
      idx_d = NW'(min_pos_n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      idx_q     <= '0;
      run_max_q <= '0;
      run_min_q <= '0;
      max_pos_q <= '0;
      min_pos_q <= '0;
      seeking_q <= 1'b0;
      peaks_q   <= '0;
      valleys_q <= '0;
      status_q  <= STAT_DONE;
    end else begin
      if (wr_en) cnt_q <= cnt_q + NW'(1);
      if (cmd_i.emit_end) cnt_q <= '0;
      if (cmd_i.start_scan) begin
        run_max_q <= v;
        run_min_q <= v;
        max_pos_q <= '0;
        min_pos_q <= '0;
        peaks_q   <= '0;
        valleys_q <= '0;
        seeking_q <= seek_q;
        idx_q     <= NW'(1);
        status_q  <= STAT_DONE;
      end
      if (cmd_i.stop) begin
        status_q <= find_peak ? STAT_PEAK_FULL : STAT_VALLEY_FULL;
      end
      if (cmd_i.step) begin
        idx_q     <= idx_d;
        run_max_q <= max_n;
        max_pos_q <= max_pos_n;
        run_min_q <= min_n;
        min_pos_q <= min_pos_n;
        // The opposite tracker restarts at the sample just found, whose value
        // the matching tracker already holds.
        if (find_peak) begin
          peaks_q   <= peaks_q + TOTAL_W'(1);
          seeking_q <= 1'b0;
          run_min_q <= max_n;
          min_pos_q <= max_pos_n;
        end else if (find_valley) begin
          valleys_q <= valleys_q + TOTAL_W'(1);
          seeking_q <= 1'b1;
          run_max_q <= min_n;
          max_pos_q <= min_pos_n;
        end
      end
    end
  end

  // Record slot.
  logic         rec_valid_q;
  dpvd_record_t rec_q;
  logic         slot_free, emit_find;

  assign slot_free = !rec_valid_q || rec_ready_i;
  assign emit_find = cmd_i.step && (find_peak || find_valley);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_q <= 1'b0;
    end else if (emit_find || cmd_i.emit_end) begin
      rec_valid_q <= 1'b1;
    end else if (rec_ready_i) begin
      rec_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_find) begin
      rec_q.record_kind  <= find_peak ? KIND_PEAK : KIND_VALLEY;
      rec_q.position     <= find_peak ? POS_W'(max_pos_n) : POS_W'(min_pos_n);
      rec_q.scan_status  <= STAT_DONE;
      rec_q.peak_total   <= find_peak ? peaks_q + TOTAL_W'(1) : peaks_q;
      rec_q.valley_total <= find_valley ? valleys_q + TOTAL_W'(1) : valleys_q;
      rec_q.last_record  <= 1'b0;
    end else if (cmd_i.emit_end) begin
      rec_q.record_kind  <= KIND_END;
      rec_q.position     <= '0;
      rec_q.scan_status  <= status_q;
      rec_q.peak_total   <= peaks_q;
      rec_q.valley_total <= valleys_q;
      rec_q.last_record  <= 1'b1;
    end
  end

  assign rec_valid_o = rec_valid_q;
  assign rec_o       = rec_q;

  assign stat_o.more      = idx_q < cnt_q;
  assign stat_o.find      = find_peak || find_valley;
  assign stat_o.cap_full  = find_peak ? (peaks_q >= pcap_q) : (valleys_q >= vcap_q);
  assign stat_o.slot_free = slot_free;

  `DPVD_ASSERT_ALWAYS(a_max_not_below_min, run_max_q >= run_min_q, "running maximum fell below running minimum")
  `DPVD_ASSERT_ALWAYS(a_count_in_range, cnt_q <= NW'(MAX_SAMPLES), "load count exceeds the store depth")
  `DPVD_ASSERT(a_end_record_shown, cmd_i.emit_end |=> rec_valid_o && rec_q.last_record && (cnt_q == '0), "end record not presented or frame not cleared")

endmodule

// ===== tb/dpvd_record_checker.sv =====
`timescale 1ns / 1ps

module dpvd_record_checker #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dpvd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dpvd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            smp_valid_i,
  input  logic                            smp_ready_i,
  input  dpvd_pkg::dpvd_sample_t          smp_payload_i,
  input  logic                            rec_valid_i,
  input  logic                            rec_ready_i,
  input  dpvd_pkg::dpvd_record_t          rec_payload_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              frames_closed_o
);
  import dpvd_pkg::*;

  // Shadow copy of the configuration registers.
  int thr;
  bit peak_first;
  int peak_cap;
  int valley_cap;

  logic signed [SAMPLE_W-1:0] frame_buf [MAX_SAMPLES];
  int frame_len;

  dpvd_record_t expected_records[$];
  int fail_cnt;
  int frames_closed;

  function automatic void queue_record(kind_e kind, int pos, status_e stat, int npk, int nvl,
                                       logic last);
    dpvd_record_t r;
    r.record_kind  = kind;
    r.position     = pos[POS_W-1:0];
    r.scan_status  = stat;
    r.peak_total   = npk[TOTAL_W-1:0];
    r.valley_total = nvl[TOTAL_W-1:0];
    r.last_record  = last;
    expected_records.push_back(r);
  endfunction

  // Walks the stored frame the way the block does and queues every record it should send.
  function automatic void predict_records();
    int n, idx, v, hi, lo, hi_pos, lo_pos, npk, nvl;
    bit want_peak;
    status_e stat;
    n = frame_len;
    hi = frame_buf[0];
    lo = hi;
    hi_pos = 0;
    lo_pos = 0;
    npk = 0;
    nvl = 0;
    want_peak = peak_first;
    idx = 1;
    stat = STAT_DONE;
    while (idx < n) begin
      v = frame_buf[idx];
      if (v > hi) begin
        hi = v;
        hi_pos = idx;
      end
      if (v < lo) begin
        lo = v;
        lo_pos = idx;
      end
      if (want_peak && v < hi - thr) begin
        if (npk >= peak_cap) begin
          stat = STAT_PEAK_FULL;
          break;
        end
        npk++;
        queue_record(KIND_PEAK, hi_pos, STAT_DONE, npk, nvl, 1'b0);
        // The scan resumes at the peak with the minimum tracker restarted there.
        want_peak = 1'b0;
        idx = hi_pos;
        lo = frame_buf[hi_pos];
        lo_pos = hi_pos;
        continue;
      end
      if (!want_peak && v > lo + thr) begin
        if (nvl >= valley_cap) begin
          stat = STAT_VALLEY_FULL;
          break;
        end
        nvl++;
        queue_record(KIND_VALLEY, lo_pos, STAT_DONE, npk, nvl, 1'b0);
        want_peak = 1'b1;
        idx = lo_pos;
        hi = frame_buf[lo_pos];
        hi_pos = lo_pos;
        continue;
      end
      idx++;
    end
    queue_record(KIND_END, 0, stat, npk, nvl, 1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    dpvd_record_t exp_rec;
    if (!rst_ni) begin
      thr = 0;
      peak_first = 1'b1;
      peak_cap = 31;
      valley_cap = 31;
      frame_len = 0;
      fail_cnt = 0;
      frames_closed = 0;
      expected_records.delete();
      fail_count_o <= 0;
      pending_o <= 0;
      frames_closed_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DELTA:      thr = int'(cfg_wdata_i);
          CFG_SEEK_PEAK:  peak_first = cfg_wdata_i[0];
          CFG_PEAK_CAP:   peak_cap = int'(cfg_wdata_i[TOTAL_W-1:0]);
          CFG_VALLEY_CAP: valley_cap = int'(cfg_wdata_i[TOTAL_W-1:0]);
          default: ;
        endcase
      end

      if (smp_valid_i && smp_ready_i) begin
        // Samples past the store size are dropped, the last flag still closes the frame.
        if (frame_len < MAX_SAMPLES) begin
          frame_buf[frame_len] = smp_payload_i.sample_value;
          frame_len++;
        end
        if (smp_payload_i.last_sample) begin
          predict_records();
          frame_len = 0;
        end
      end

      if (rec_valid_i && rec_ready_i) begin
        if (rec_payload_i.last_record === 1'b1) frames_closed++;
        if (expected_records.size() == 0) begin
          if (fail_cnt < 10) begin
            $display("%0t: unexpected record kind=%0d pos=%0d st=%0d pk=%0d vl=%0d last=%0d",
                     $realtime, rec_payload_i.record_kind, rec_payload_i.position,
                     rec_payload_i.scan_status, rec_payload_i.peak_total,
                     rec_payload_i.valley_total, rec_payload_i.last_record);
          end
          fail_cnt++;
        end else begin
          exp_rec = expected_records.pop_front();
          if (rec_payload_i.record_kind  !== exp_rec.record_kind  ||
              rec_payload_i.position     !== exp_rec.position     ||
              rec_payload_i.scan_status  !== exp_rec.scan_status  ||
              rec_payload_i.peak_total   !== exp_rec.peak_total   ||
              rec_payload_i.valley_total !== exp_rec.valley_total ||
              rec_payload_i.last_record  !== exp_rec.last_record) begin
            if (fail_cnt < 10) begin
              $display("%0t: record differs, exp kind=%0d pos=%0d st=%0d pk=%0d vl=%0d last=%0d",
                       $realtime, exp_rec.record_kind, exp_rec.position, exp_rec.scan_status,
                       exp_rec.peak_total, exp_rec.valley_total, exp_rec.last_record);
              $display("%0t:               got kind=%0d pos=%0d st=%0d pk=%0d vl=%0d last=%0d",
                       $realtime, rec_payload_i.record_kind, rec_payload_i.position,
                       rec_payload_i.scan_status, rec_payload_i.peak_total,
                       rec_payload_i.valley_total, rec_payload_i.last_record);
            end
            fail_cnt++;
          end
        end
      end

      fail_count_o <= fail_cnt;
      pending_o <= expected_records.size();
      frames_closed_o <= frames_closed;
    end
  end

endmodule

// ===== tb/delta_peak_valley_detector_unit_tb.sv =====
`timescale 1ns / 1ps

module delta_peak_valley_detector_unit_tb;
  import dpvd_pkg::*;

  localparam int MAX_SAMPLES   = 1024;
  localparam int IDLE_LIMIT    = 20000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {
    SHAPE_NOISE,
    SHAPE_WALK,
    SHAPE_SWING
  } shape_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dpvd_stream_if #(.payload_t(dpvd_sample_t)) smp_if ();
  dpvd_stream_if #(.payload_t(dpvd_record_t)) rec_if ();

  int fail_count;
  int pending;
  int frames_closed;
  int frames_sent;
  int send_idle_pct;
  int stall_pct;
  int hold_token;
  int hold_seen;
  int idle_cycles;
  int cur_delta;
  int frame[$];

  delta_peak_valley_detector_unit #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .smp_i      (smp_if),
    .rec_o      (rec_if)
  );

  dpvd_record_checker #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) rec_check (
    .clk_i,
    .rst_ni,
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .smp_valid_i    (smp_if.valid),
    .smp_ready_i    (smp_if.ready),
    .smp_payload_i  (smp_if.payload),
    .rec_valid_i    (rec_if.valid),
    .rec_ready_i    (rec_if.ready),
    .rec_payload_i  (rec_if.payload),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .frames_closed_o(frames_closed)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Record side: random stalls, or one long hold-off whenever the stimulus asks for it.
  initial begin : record_sink
    rec_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        rec_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        rec_if.ready <= ($urandom_range(99) >= stall_pct);
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((smp_if.valid && smp_if.ready) || (rec_if.valid && rec_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_sample(input int val, input logic last);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_if.valid <= 1'b1;
    smp_if.payload <= {val[SAMPLE_W-1:0], last};
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
  endtask

  task automatic send_frame();
    foreach (frame[k]) push_sample(frame[k], k == frame.size() - 1);
    frames_sent++;
  endtask

  // Drops valid, waits until every frame sent has been closed and checked, then lets the bench settle.
  task automatic wait_idle();
    smp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (frames_closed != frames_sent || pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input int delta, input int seek, input int pcap, input int vcap);
    wait_idle();
    cur_delta = delta;
    cfg_we <= 1'b1;
    cfg_idx <= CFG_DELTA;
    cfg_wdata <= delta[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_idx <= CFG_SEEK_PEAK;
    cfg_wdata <= CFG_DATA_W'(seek[0]);
    @(posedge clk_i);
    cfg_idx <= CFG_PEAK_CAP;
    cfg_wdata <= CFG_DATA_W'(pcap[TOTAL_W-1:0]);
    @(posedge clk_i);
    cfg_idx <= CFG_VALLEY_CAP;
    cfg_wdata <= CFG_DATA_W'(vcap[TOTAL_W-1:0]);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic int random_capacity();
    case ($urandom_range(4))
      0: return 0;
      1: return 1;
      2: return int'($urandom_range(3));
      3: return int'($urandom_range(31));
      default: return 31;
    endcase
  endfunction

  // Swing frames ramp by at least a third of the threshold per sample, plus a random part, and turn at random,
  // so excursions straddle the threshold and finds are frequent.
  task automatic make_frame(input shape_e shape, input int len);
    int cur, dir, span;
    frame.delete();
    cur = int'($urandom_range(65535)) - 32768;
    dir = 1;
    for (int k = 0; k < len; k++) begin
      case (shape)
        SHAPE_NOISE: cur = int'($urandom_range(65535)) - 32768;
        SHAPE_WALK: begin
          span = cur_delta / 2 + 16;
          cur = cur + int'($urandom_range(2 * span)) - span;
        end
        default: begin
          if ($urandom_range(3) == 0) dir = -dir;
          cur = cur + dir * (cur_delta / 3 + 1 + int'($urandom_range(cur_delta / 4 + 8)));
        end
      endcase
      if (cur > 32767) cur = 32767;
      if (cur < -32768) cur = -32768;
      frame.push_back(cur);
    end
  endtask

  initial begin : stimulus
    int d, len, pick;
    shape_e shape;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_DELTA;
    cfg_wdata <= '0;
    smp_if.valid <= 1'b0;
    smp_if.payload <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(0, 1, 31, 31);
    // A frame of one sample closes with no finds.
    frame = {32767};
    send_frame();
    frame = {-32768, 32767, -32768, 32767, 0};
    send_frame();
    // The full-range swing only equals the largest threshold, so nothing is found.
    configure(65535, 0, 31, 31);
    frame = {-32768, 32767, -32768};
    send_frame();
    configure(65534, 1, 31, 31);
    frame = {32767, -32768, 32767};
    send_frame();
    // With no room for peaks or valleys the first find ends the scan.
    configure(10, 1, 0, 31);
    frame = {0, 100, 0};
    send_frame();
    configure(10, 0, 31, 0);
    frame = {100, 0, 100};
    send_frame();
    configure(5, 1, 1, 31);
    frame = {0, 50, 0, 50, 0, 50};
    send_frame();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 68;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 68;
        end
        default: begin
          send_idle_pct = 37;
          stall_pct = 37;
        end
      endcase
      for (int s = 0; s < 2; s++) begin
        case ($urandom_range(4))
          0: d = 0;
          1: d = int'($urandom_range(20));
          2: d = int'($urandom_range(2000));
          3: d = int'($urandom_range(65535));
          default: d = 65535;
        endcase
        configure(d, int'($urandom_range(1)), random_capacity(), random_capacity());
        for (int f = 0; f < 2; f++) begin
          pick = int'($urandom_range(4));
          shape = (pick == 0) ? SHAPE_NOISE : (pick == 1) ? SHAPE_WALK : SHAPE_SWING;
          pick = int'($urandom_range(9));
          len = (pick == 0) ? 1 : (pick == 9) ? int'($urandom_range(30, 13))
                                              : int'($urandom_range(10, 2));
          make_frame(shape, len);
          send_frame();
        end
      end
      if (ph == 0) begin
        // Hold the record side off while the next frame keeps being offered behind it.
        configure(3000, 1, 31, 31);
        make_frame(SHAPE_SWING, 12);
        send_frame();
        hold_token++;
        make_frame(SHAPE_NOISE, 10);
        send_frame();
      end
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
